### hw/rtl/sbda_pkg.sv
// ----------------------------------------------------------------------------
// sbda_pkg
// Shared types and constants for the signed binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package sbda_pkg;

    localparam logic [5:0] CHAR_ZERO  = 6'd48;
    localparam logic [5:0] CHAR_MINUS = 6'd45;
    localparam logic [5:0] DIGIT_MAX  = 6'd9;

    localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0] BCD_ADJ     = 4'd3;

    typedef enum logic [1:0] {
        DAB_IDLE,
        DAB_RUN,
        DAB_DONE
    } dab_state_t;

    typedef enum logic [1:0] {
        EMT_IDLE,
        EMT_SKIP,
        EMT_SIGN,
        EMT_DIGIT
    } emt_state_t;

    typedef struct packed {
        logic valid;
        logic neg;
    } res_ctl_t;

endpackage

### hw/rtl/signed_binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, one character per
// transaction, most significant first, with last on the final character.
// ----------------------------------------------------------------------------
// A value is taken while the converter is idle and converted to BCD by a
// shift-add-3 unit that consumes one magnitude bit per cycle; the digits are
// then handed to the character emitter. A new value is accepted only after
// the previous one has been handed over, and as long as characters are
// taken the emitter sends the previous number's text while the next one
// converts. The emitter drops one leading zero per cycle and then sends '-'
// for negative values and one digit per transaction; zero gives a single
// '0', and the most negative value converts correctly.
module signed_binary_to_decimal_ascii #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          value_valid,
    output logic                          value_ready,
    output logic [5:0]                    char_code,
    output logic                          last,
    output logic                          char_valid,
    input  logic                          char_ready
);

    localparam int NDIG = ((VALUE_WIDTH - 1) * 1233) / 4096 + 1;

    sbda_pkg::res_ctl_t res;
    logic [4*NDIG-1:0]  bcd;
    logic               res_ready;

    sbda_dabble #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG)
    ) u_dabble (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .res         (res),
        .bcd         (bcd),
        .res_ready   (res_ready)
    );

    sbda_emit #(
        .NDIG (NDIG)
    ) u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .res        (res),
        .bcd        (bcd),
        .res_ready  (res_ready),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_code  (char_code),
        .last       (last)
    );

endmodule

### hw/rtl/sbda_dabble.sv
// ----------------------------------------------------------------------------
// sbda_dabble
// Bit-serial shift-add-3 converter: signed value in, sign and packed BCD digits of the magnitude out.
// ----------------------------------------------------------------------------
module sbda_dabble #(
    parameter int VALUE_WIDTH = 32,
    parameter int NDIG        = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          value_valid,
    output logic                          value_ready,
    output sbda_pkg::res_ctl_t            res,
    output logic [4*NDIG-1:0]             bcd,
    input  logic                          res_ready
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] LAST_CNT = CW'(VALUE_WIDTH - 1);

    sbda_pkg::dab_state_t     state_reg, state_next;
    logic [VALUE_WIDTH-1:0]   mag_reg, mag_next;
    logic [4*NDIG-1:0]        bcd_reg, bcd_next;
    logic [4*NDIG-1:0]        adj;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;

    always_comb
    begin
        for (int i = 0; i < NDIG; i++)
        begin
            if (bcd_reg[4*i +: 4] >= sbda_pkg::BCD_ADJ_MIN)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + sbda_pkg::BCD_ADJ;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        mag_next    = mag_reg;
        bcd_next    = bcd_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        value_ready = 1'b0;
        res.valid   = 1'b0;
        res.neg     = neg_reg;
        unique case (state_reg)
            sbda_pkg::DAB_IDLE:
            begin
                value_ready = 1'b1;
                if (value_valid)
                begin
                    neg_next   = value[VALUE_WIDTH-1];
                    mag_next   = value[VALUE_WIDTH-1] ? (~value) + VALUE_WIDTH'(1) : value;
                    bcd_next   = '0;
                    cnt_next   = '0;
                    state_next = sbda_pkg::DAB_RUN;
                end
            end
            sbda_pkg::DAB_RUN:
            begin
                bcd_next = {adj[4*NDIG-2:0], mag_reg[VALUE_WIDTH-1]};
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                    state_next = sbda_pkg::DAB_DONE;
            end
            sbda_pkg::DAB_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                    state_next = sbda_pkg::DAB_IDLE;
            end
            default:
                state_next = sbda_pkg::DAB_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbda_pkg::DAB_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

    assign bcd = bcd_reg;

    a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        value_valid && value_ready |=> state_reg == sbda_pkg::DAB_RUN && cnt_reg == '0
                                       && bcd_reg == '0)
        else $error("converter did not start cleanly after load");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sbda_pkg::DAB_DONE && !res_ready
            |=> state_reg == sbda_pkg::DAB_DONE && $stable(bcd_reg) && $stable(neg_reg))
        else $error("finished result changed before handoff");

endmodule

### hw/rtl/sbda_emit.sv
// ----------------------------------------------------------------------------
// sbda_emit
// Walks the BCD digits most significant first, drops leading zeros and sends
// one ASCII character per transaction through an output register.
// ----------------------------------------------------------------------------
module sbda_emit #(
    parameter int NDIG = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sbda_pkg::res_ctl_t res,
    input  logic [4*NDIG-1:0]  bcd,
    output logic               res_ready,
    output logic               char_valid,
    input  logic               char_ready,
    output logic [5:0]         char_code,
    output logic               last
);

    localparam int CW = $clog2(NDIG);

    sbda_pkg::emt_state_t state_reg, state_next;
    logic [4*NDIG-1:0]    dig_reg, dig_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 neg_reg, neg_next;
    logic                 cv_reg, cv_next;
    logic [5:0]           code_reg, code_next;
    logic                 last_reg, last_next;
    logic [3:0]           top;
    logic                 slot_free;

    assign top       = dig_reg[4*NDIG-1 -: 4];
    assign slot_free = !cv_reg || char_ready;

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        cv_next    = cv_reg && !char_ready;
        code_next  = code_reg;
        last_next  = last_reg;
        res_ready  = 1'b0;
        unique case (state_reg)
            sbda_pkg::EMT_IDLE:
            begin
                res_ready = 1'b1;
                if (res.valid)
                begin
                    dig_next   = bcd;
                    cnt_next   = CW'(NDIG - 1);
                    neg_next   = res.neg;
                    state_next = sbda_pkg::EMT_SKIP;
                end
            end
            sbda_pkg::EMT_SKIP:
            begin
                if (top == 4'd0 && cnt_reg != '0)
                begin
                    dig_next = {dig_reg[4*NDIG-5:0], 4'b0000};
                    cnt_next = cnt_reg - 1'b1;
                end
                else
                    state_next = neg_reg ? sbda_pkg::EMT_SIGN : sbda_pkg::EMT_DIGIT;
            end
            sbda_pkg::EMT_SIGN:
            begin
                if (slot_free)
                begin
                    cv_next    = 1'b1;
                    code_next  = sbda_pkg::CHAR_MINUS;
                    last_next  = 1'b0;
                    state_next = sbda_pkg::EMT_DIGIT;
                end
            end
            sbda_pkg::EMT_DIGIT:
            begin
                if (slot_free)
                begin
                    cv_next   = 1'b1;
                    code_next = sbda_pkg::CHAR_ZERO + {2'b00, top};
                    last_next = (cnt_reg == '0);
                    dig_next  = {dig_reg[4*NDIG-5:0], 4'b0000};
                    cnt_next  = cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_next = sbda_pkg::EMT_IDLE;
                end
            end
            default:
                state_next = sbda_pkg::EMT_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbda_pkg::EMT_IDLE;
            cv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cv_reg    <= cv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        code_reg <= code_next;
        last_reg <= last_next;
    end

    assign char_valid = cv_reg;
    assign char_code  = code_reg;
    assign last       = last_reg;

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg |-> code_reg == sbda_pkg::CHAR_MINUS
                   || (code_reg >= sbda_pkg::CHAR_ZERO
                       && code_reg <= sbda_pkg::CHAR_ZERO + sbda_pkg::DIGIT_MAX))
        else $error("illegal character code");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        cv_reg && last_reg |-> code_reg != sbda_pkg::CHAR_MINUS)
        else $error("sign character flagged as last");

    a_final_digit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sbda_pkg::EMT_DIGIT && slot_free && cnt_reg == '0
            |=> state_reg == sbda_pkg::EMT_IDLE && cv_reg && last_reg)
        else $error("final digit not closed with last");

endmodule

### dv/sbda_text_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbda_text_checker
// Watches both channels of the decimal ASCII converter, works out the text of
// every accepted value and compares each accepted character, in order, with
// the oldest character still owed. Reports mismatch and backlog counts.
// ----------------------------------------------------------------------------
module sbda_text_checker #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic signed [VALUE_WIDTH-1:0] value,
    input  logic                          value_valid,
    input  logic                          value_ready,
    input  logic [5:0]                    char_code,
    input  logic                          last,
    input  logic                          char_valid,
    input  logic                          char_ready,
    output int                            mismatch_count,
    output int                            chars_pending
);

    typedef struct packed {
        logic [5:0] code;
        logic       fin;
    } ascii_char_t;

    ascii_char_t owed_text_q[$];
    ascii_char_t owed;
    int          mismatches = 0;

    // Decimal text of one value, sign first, no leading zeros
    function automatic void push_decimal_text(input logic [VALUE_WIDTH-1:0] v);
        logic [VALUE_WIDTH-1:0] mag;
        logic [3:0]             digits [0:19];
        int                     nd;
        ascii_char_t            c;
        nd  = 0;
        mag = v;
        if (v[VALUE_WIDTH-1])
            mag = ~v + 1'b1;
        do
        begin
            digits[nd] = 4'(mag % 10);
            mag        = mag / 10;
            nd++;
        end
        while (mag != 0);
        if (v[VALUE_WIDTH-1])
        begin
            c.code = sbda_pkg::CHAR_MINUS;
            c.fin  = 1'b0;
            owed_text_q.push_back(c);
        end
        for (int i = nd - 1; i >= 0; i--)
        begin
            c.code = sbda_pkg::CHAR_ZERO + 6'(digits[i]);
            c.fin  = (i == 0);
            owed_text_q.push_back(c);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && char_ready)
            begin
                if (owed_text_q.size() == 0)
                begin
                    $error("unexpected character: char_code %0d last %0b", char_code, last);
                    mismatches++;
                end
                else
                begin
                    owed = owed_text_q.pop_front();
                    if (char_code !== owed.code)
                    begin
                        $error("char_code mismatch: expected %0d, actual %0d",
                               owed.code, char_code);
                        mismatches++;
                    end
                    if (last !== owed.fin)
                    begin
                        $error("last mismatch: expected %0b, actual %0b", owed.fin, last);
                        mismatches++;
                    end
                end
            end
            if (value_valid && value_ready)
                push_decimal_text(value);
        end
        mismatch_count <= mismatches;
        chars_pending  <= owed_text_q.size();
    end

endmodule

### dv/signed_binary_to_decimal_ascii_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii_tb
// Feeds signed integers into the decimal ASCII converter: edge values first,
// then random values of every length and sign, with random stalls on both
// channels and one long output hold-off. A checker beside the block predicts
// each character and counts mismatches.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii_tb;

    localparam int VALUE_WIDTH  = 32;
    localparam int RANDOM_ITEMS = 148;
    localparam int NUM_DIRECTED = 22;
    localparam int TOTAL_ITEMS  = NUM_DIRECTED + RANDOM_ITEMS;
    localparam int CALM_ITEMS   = 30;

    logic                          clk;
    logic                          rst_n;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          value_valid;
    logic                          value_ready;
    logic [5:0]                    char_code;
    logic                          last;
    logic                          char_valid;
    logic                          char_ready;

    int mismatch_count;
    int chars_pending;
    int values_sent = 0;
    bit calm        = 1'b0;
    bit held_off    = 1'b0;

    logic [31:0] directed [NUM_DIRECTED];

    signed_binary_to_decimal_ascii #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (value),
        .value_valid (value_valid),
        .value_ready (value_ready),
        .char_code   (char_code),
        .last        (last),
        .char_valid  (char_valid),
        .char_ready  (char_ready)
    );

    sbda_text_checker #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .value          (value),
        .value_valid    (value_valid),
        .value_ready    (value_ready),
        .char_code      (char_code),
        .last           (last),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .mismatch_count (mismatch_count),
        .chars_pending  (chars_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Mostly values of a random digit count, some full-range words, a few zeros
    function automatic logic [31:0] pick_value();
        longint lo;
        longint hi;
        logic [31:0] mag;
        int          nd;
        lo = 1;
        case ($urandom_range(0, 9))
            0:
                return '0;
            1, 2:
                return $urandom();
            default:
            begin
                nd = $urandom_range(1, 10);
                repeat (nd - 1) lo = lo * 10;
                hi = lo * 10 - 1;
                if (hi > 64'sd2147483647)
                    hi = 64'sd2147483647;
                mag = 32'(lo + (longint'($urandom()) % (hi - lo + 1)));
                if ($urandom_range(0, 1))
                    mag = -mag;
                return mag;
            end
        endcase
    endfunction

    task automatic send_value(input logic [31:0] v);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            value_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        value       <= v;
        value_valid <= 1'b1;
        @(posedge clk);
        while (!value_ready) @(posedge clk);
        values_sent++;
        calm = (values_sent >= TOTAL_ITEMS - CALM_ITEMS);
    endtask

    // Receiver: random stall bursts, one long hold-off to back the block up
    initial
    begin
        char_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && values_sent >= 40)
            begin
                held_off = 1'b1;
                char_ready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 2) == 0)
            begin
                char_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                char_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        directed = '{
            32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd9,
            32'd10,        -32'sd10,      32'd99,        32'd100,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd999999999, 32'd12345,   -32'sd12345,
            32'd7,         -32'sd7,       32'h5555_5555, 32'hAAAA_AAAA,
            32'd1000,      -32'sd100000
        };
        rst_n       <= 1'b0;
        value       <= '0;
        value_valid <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(directed[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            send_value(pick_value());
        value_valid <= 1'b0;

        @(posedge clk);
        while (chars_pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (mismatch_count == 0 && chars_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### sim.f
hw/rtl/sbda_pkg.sv
hw/rtl/sbda_dabble.sv
hw/rtl/sbda_emit.sv
hw/rtl/signed_binary_to_decimal_ascii.sv
dv/sbda_text_checker.sv
dv/signed_binary_to_decimal_ascii_tb.sv
